/* rtl/bpe_pkg.sv */
// shared types, constants and lookup tables of the breakpoint envelope evaluator
package bpe_pkg;

	localparam int POINTS = 8;
	localparam int PT_AW = $clog2(POINTS);
	localparam int LOG_TABLE_ENTRIES = 256;
	localparam int LB = $clog2(LOG_TABLE_ENTRIES);
	localparam int TAB_AW = LB + 1;
	localparam int FRAC_W = 30 - LB;
	localparam logic [23:0] TIME_MAX = 24'hFFFFFF;
	localparam logic [24:0] TIME_GAP = 25'd10;
	localparam logic signed [31:0] LOG_FLOOR = 32'sd66;
	localparam logic [63:0] ONE30 = 64'h1 << 30;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_EVAL  = 1'b1
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [2:0]         point_index;
		logic [23:0]        point_time;
		logic signed [31:0] point_level;
		logic signed [15:0] point_bend;
		logic [23:0]        eval_time;
	} item_t;

	typedef struct packed {
		logic signed [31:0] level;
		logic [23:0]        total_duration;
	} result_t;

	typedef struct packed {
		logic [23:0]        tm;
		logic signed [31:0] lvl;
		logic signed [15:0] bnd;
	} pt_t;

	typedef enum logic {
		OP_LOG2,
		OP_EXP2
	} mu_op_t;

	typedef struct packed {
		logic        start;
		mu_op_t      op;
		logic [31:0] arg;
	} mu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] value;
	} mu_rsp_t;

	typedef enum logic [2:0] {
		MU_IDLE,
		MU_NORM,
		MU_LOOK,
		MU_MULT,
		MU_SUM,
		MU_SHIFT,
		MU_DONE
	} mu_state_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_DECIDE,
		ST_DIV,
		ST_SHAPE,
		ST_PLOG,
		ST_PMUL,
		ST_PCHK,
		ST_PEXP,
		ST_PFIN,
		ST_INTERP,
		ST_LMUL,
		ST_LSUM,
		ST_GLS,
		ST_GLE,
		ST_GMUL,
		ST_GSUM,
		ST_GEXP,
		ST_OUT
	} state_t;

	typedef logic [17:0] tab_t [0:LOG_TABLE_ENTRIES];

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bt;
		v = v_in;
		res = '0;
		bt = 64'h1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic tab_t build_lg();
		tab_t t;
		logic [63:0] m;
		logic [17:0] r;
		for (int k = 0; k <= LOG_TABLE_ENTRIES; k++) begin
			if (k == LOG_TABLE_ENTRIES) begin
				t[k] = 18'd65536;
			end else begin
				m = ONE30 + ((64'(k) << 30) / LOG_TABLE_ENTRIES);
				r = '0;
				for (int b = 15; b >= 0; b--) begin
					m = (m * m) >> 30;
					if (m >= 2 * ONE30) begin
						m = m >> 1;
						r[b] = 1'b1;
					end
				end
				t[k] = r;
			end
		end
		return t;
	endfunction

	function automatic tab_t build_ex();
		tab_t t;
		logic [63:0] roots [1:16];
		logic [63:0] c;
		logic [63:0] m;
		logic [63:0] f;
		c = 2 * ONE30;
		for (int j = 1; j <= 16; j++) begin
			c = isqrt64(c << 30);
			roots[j] = c;
		end
		for (int k = 0; k <= LOG_TABLE_ENTRIES; k++) begin
			if (k == LOG_TABLE_ENTRIES) begin
				t[k] = 18'd131072;
			end else begin
				f = (64'(k) << 16) / LOG_TABLE_ENTRIES;
				m = ONE30;
				for (int j = 1; j <= 16; j++) begin
					if (f[16 - j]) m = (m * roots[j]) >> 30;
				end
				t[k] = 18'(m >> 14);
			end
		end
		return t;
	endfunction

	localparam tab_t LG_TAB = build_lg();
	localparam tab_t EX_TAB = build_ex();

endpackage

/* rtl/bpe_logexp.sv */
// shared iterative log2 / exp2 unit with table interpolation
module bpe_logexp import bpe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mu_req_t req,
	output mu_rsp_t rsp
);

	mu_state_t state_q, state_nxt;
	logic [2:0] step_q;
	mu_op_t op_q;
	logic [31:0] arg_q;
	logic [31:0] norm_q;
	logic [4:0] sh_q;
	logic [17:0] lo_q;
	logic [17:0] dif_q;
	logic [FRAC_W-1:0] frac_q;
	logic [17+FRAC_W:0] prod_q;
	logic [31:0] res_q;

	logic [5:0] amt;
	logic top_zero;
	logic [LB-1:0] kidx;
	logic [TAB_AW-1:0] kidx0;
	logic [TAB_AW-1:0] kidx1;
	logic [17:0] t_lo;
	logic [17:0] t_hi;
	logic [FRAC_W-1:0] frac;
	logic [4:0] p;
	logic [56:0] w;
	logic sat;

	always_comb begin
		amt = 6'(16 >> step_q);
		top_zero = (norm_q >> (6'd32 - amt)) == '0;
		kidx = (op_q == OP_LOG2) ? norm_q[30 -: LB] : arg_q[15 -: LB];
		kidx0 = TAB_AW'(kidx);
		kidx1 = kidx0 + TAB_AW'(1);
		t_lo = (op_q == OP_LOG2) ? LG_TAB[kidx0] : EX_TAB[kidx0];
		t_hi = (op_q == OP_LOG2) ? LG_TAB[kidx1] : EX_TAB[kidx1];
		frac = (op_q == OP_LOG2) ? norm_q[30-LB:1] : FRAC_W'(arg_q[15-LB:0]);
		p = 5'd31 - sh_q;
		w = 57'(res_q[17:0]) << arg_q[21:16];
		sat = (arg_q[31:16] >= 16'd40) || (|w[56:47]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MU_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == MU_NORM) step_q <= step_q + 3'd1;
			else step_q <= '0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			MU_IDLE: begin
				if (req.start) state_nxt = (req.op == OP_LOG2) ? MU_NORM : MU_LOOK;
			end
			MU_NORM: begin
				if (step_q == 3'd4) state_nxt = MU_LOOK;
			end
			MU_LOOK: state_nxt = MU_MULT;
			MU_MULT: state_nxt = MU_SUM;
			MU_SUM: state_nxt = (op_q == OP_LOG2) ? MU_DONE : MU_SHIFT;
			MU_SHIFT: state_nxt = MU_DONE;
			MU_DONE: state_nxt = MU_IDLE;
			default: state_nxt = MU_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MU_IDLE: begin
				op_q <= req.op;
				arg_q <= req.arg;
				norm_q <= req.arg;
				sh_q <= '0;
			end
			MU_NORM: begin
				if (top_zero) begin
					norm_q <= norm_q << amt;
					sh_q <= sh_q + 5'(amt);
				end
			end
			MU_LOOK: begin
				lo_q <= t_lo;
				dif_q <= t_hi - t_lo;
				frac_q <= frac;
			end
			MU_MULT: prod_q <= (18+FRAC_W)'(dif_q) * (18+FRAC_W)'(frac_q);
			MU_SUM: begin
				if (op_q == OP_LOG2)
					res_q <= 32'({p, 16'h0000}) + 32'(lo_q) + 32'(prod_q >> (30 - LB));
				else
					res_q <= 32'(lo_q) + 32'(prod_q >> (16 - LB));
			end
			MU_SHIFT: res_q <= sat ? 32'h7FFFFFFF : {1'b0, w[46:16]};
			default: ;
		endcase
	end

	assign rsp.done = (state_q == MU_DONE);
	assign rsp.value = res_q;

endmodule

/* rtl/breakpoint_envelope_evaluator.sv */
// top level of the breakpoint envelope evaluator: breakpoint memory, sequencer, interpolation
//
//  channel   ports                              transaction
//  input     start, busy, item                  start & !busy
//  result    done, result                       done, one cycle, no back pressure
//  config    cfg_valid, cfg_ready, cfg_data     cfg_valid & cfg_ready
//
// a write passes through ST_WRITE; an evaluate scans all breakpoints, then may use the divider
// and the shared log2 / exp2 unit (two runs for a bent segment, three more in log mode).
// breakpoints reset to zero through per-entry valid flags; log_mode resets to 0.
// one item at a time: busy stays high until the write is done or the result strobe has been given.
module breakpoint_envelope_evaluator import bpe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  logic    cfg_data
);

	state_t state_q, state_nxt;
	logic log_mode_q;
	item_t it_q;

	pt_t mem_q [POINTS];
	logic [POINTS-1:0] vld_q;
	pt_t rd_s1;
	logic rd_vld_s1;
	logic mem_we;
	logic [PT_AW-1:0] mem_wa;
	logic [PT_AW-1:0] mem_ra;
	pt_t mem_wd;
	pt_t ent;

	logic [PT_AW:0] iss_q;
	logic rv_s1;
	logic [PT_AW-1:0] ri_s1;
	logic found_q;
	logic [4:0] div_cnt_q;

	logic [23:0] t0_q, tl_q, st_q, et_q, pv_t_q;
	logic signed [31:0] l0_q, ll_q, sv_q, ev_q, pv_l_q;
	logic signed [15:0] sb_q, pv_b_q;
	logic [24:0] r_q;
	logic [23:0] dv_q;
	logic [16:0] q_q, u_q, uz_q, x_q, p_q;
	logic [17:0] e_q;
	logic pos_q;
	logic [20:0] dl_q;
	logic [23:0] neg_q;
	logic [31:0] ls_q, le_q, y_q;
	logic signed [50:0] prod_q;
	logic signed [31:0] level_q;

	mu_req_t mu_req;
	mu_rsp_t mu_rsp;

	logic accept;
	logic [24:0] min_t;
	logic [23:0] new_t;
	logic ge;
	logic [24:0] rem;
	logic signed [16:0] sbx;
	logic [16:0] babs;
	logic signed [31:0] svc, evc;
	logic signed [32:0] dif_a;
	logic [23:0] t_ev;

	bpe_logexp u_logexp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mu_req),
		.rsp    (mu_rsp)
	);

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_OUT);
	assign cfg_ready = 1'b1;
	assign result.level = level_q;
	assign result.total_duration = tl_q;
	assign t_ev = it_q.eval_time;
	assign ent = rd_vld_s1 ? rd_s1 : pt_t'('0);

	always_comb begin
		min_t = 25'(ent.tm) + TIME_GAP;
		if (min_t > 25'(TIME_MAX)) min_t = 25'(TIME_MAX);
		if (it_q.point_index == 3'd0) new_t = '0;
		else if (25'(it_q.point_time) < min_t) new_t = min_t[23:0];
		else new_t = it_q.point_time;
		ge = r_q >= 25'(dv_q);
		rem = ge ? r_q - 25'(dv_q) : r_q;
		sbx = 17'(sb_q);
		babs = sb_q[15] ? 17'(-sbx) : 17'(sbx);
		svc = (sv_q < LOG_FLOOR) ? LOG_FLOOR : sv_q;
		evc = (ev_q < LOG_FLOOR) ? LOG_FLOOR : ev_q;
		if (state_q == ST_GMUL) dif_a = $signed({1'b0, le_q}) - $signed({1'b0, ls_q});
		else dif_a = 33'(ev_q) - 33'(sv_q);
	end

	always_comb begin
		mem_we = (state_q == ST_WRITE);
		mem_wa = PT_AW'(it_q.point_index);
		mem_wd.tm = new_t;
		mem_wd.lvl = it_q.point_level;
		mem_wd.bnd = it_q.point_bend;
		if (state_q == ST_SCAN) mem_ra = iss_q[PT_AW-1:0];
		else mem_ra = PT_AW'(item.point_index) - PT_AW'(1);
		mu_req.start = state_q inside {ST_PLOG, ST_PEXP, ST_GLS, ST_GLE, ST_GEXP};
		mu_req.op = (state_q inside {ST_PEXP, ST_GEXP}) ? OP_EXP2 : OP_LOG2;
		case (state_q)
			ST_PLOG: mu_req.arg = 32'(x_q);
			ST_PEXP: mu_req.arg = 32'(21'h100000 - neg_q[20:0]);
			ST_GLS: mu_req.arg = svc;
			ST_GLE: mu_req.arg = evc;
			default: mu_req.arg = y_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		rd_s1 <= mem_q[mem_ra];
	end

	// shaping input is zero or full scale: power needs no log/exp run
	function automatic logic x_nxt_zero_or_one();
		logic [16:0] x;
		x = sb_q[15] ? 17'h10000 - u_q : u_q;
		return (x == '0) || (x >= 17'h10000);
	endfunction

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.action == ACT_EVAL) state_nxt = ST_SCAN;
					else if (32'(item.point_index) < POINTS) state_nxt = ST_WRITE;
				end
			end
			ST_WRITE: state_nxt = ST_IDLE;
			ST_SCAN: begin
				if (rv_s1 && ri_s1 == PT_AW'(POINTS - 1)) state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (t_ev <= t0_q || t_ev >= tl_q || !found_q) state_nxt = ST_OUT;
				else if (et_q <= st_q || t_ev <= st_q) state_nxt = ST_SHAPE;
				else state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (div_cnt_q == 5'd0) state_nxt = ST_SHAPE;
			end
			ST_SHAPE: begin
				if (sb_q == '0) state_nxt = ST_INTERP;
				else if (x_nxt_zero_or_one()) state_nxt = ST_PFIN;
				else state_nxt = ST_PLOG;
			end
			ST_PLOG: begin
				if (mu_rsp.done) state_nxt = ST_PMUL;
			end
			ST_PMUL: state_nxt = ST_PCHK;
			ST_PCHK: state_nxt = (neg_q > 24'h100000) ? ST_PFIN : ST_PEXP;
			ST_PEXP: begin
				if (mu_rsp.done) state_nxt = ST_PFIN;
			end
			ST_PFIN: state_nxt = ST_INTERP;
			ST_INTERP: state_nxt = log_mode_q ? ST_GLS : ST_LMUL;
			ST_LMUL: state_nxt = ST_LSUM;
			ST_LSUM: state_nxt = ST_OUT;
			ST_GLS: begin
				if (mu_rsp.done) state_nxt = ST_GLE;
			end
			ST_GLE: begin
				if (mu_rsp.done) state_nxt = ST_GMUL;
			end
			ST_GMUL: state_nxt = ST_GSUM;
			ST_GSUM: state_nxt = ST_GEXP;
			ST_GEXP: begin
				if (mu_rsp.done) state_nxt = ST_OUT;
			end
			ST_OUT: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			log_mode_q <= 1'b0;
			vld_q <= '0;
			rd_vld_s1 <= 1'b0;
			iss_q <= '0;
			rv_s1 <= 1'b0;
			found_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready) log_mode_q <= cfg_data;
			if (mem_we) vld_q[mem_wa] <= 1'b1;
			rd_vld_s1 <= vld_q[mem_ra];
			rv_s1 <= (state_q == ST_SCAN) && (32'(iss_q) < POINTS);
			if (state_q == ST_IDLE) begin
				iss_q <= '0;
				found_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (32'(iss_q) < POINTS) iss_q <= iss_q + 1'b1;
				if (rv_s1 && ri_s1 != '0 && !found_q && t_ev <= ent.tm) found_q <= 1'b1;
			end
			if (state_q == ST_DECIDE) div_cnt_q <= 5'd16;
			else if (state_q == ST_DIV) div_cnt_q <= div_cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) it_q <= item;
		ri_s1 <= iss_q[PT_AW-1:0];
		case (state_q)
			ST_SCAN: begin
				if (rv_s1) begin
					if (ri_s1 == '0) begin
						t0_q <= ent.tm;
						l0_q <= ent.lvl;
					end else if (!found_q && t_ev <= ent.tm) begin
						st_q <= pv_t_q;
						sv_q <= pv_l_q;
						sb_q <= pv_b_q;
						et_q <= ent.tm;
						ev_q <= ent.lvl;
					end
					pv_t_q <= ent.tm;
					pv_l_q <= ent.lvl;
					pv_b_q <= ent.bnd;
					if (ri_s1 == PT_AW'(POINTS - 1)) begin
						tl_q <= ent.tm;
						ll_q <= ent.lvl;
					end
				end
			end
			ST_DECIDE: begin
				if (t_ev <= t0_q) level_q <= l0_q;
				else if (t_ev >= tl_q || !found_q) level_q <= ll_q;
				else if (et_q <= st_q) u_q <= 17'h10000;
				else if (t_ev <= st_q) u_q <= '0;
				r_q <= 25'(t_ev - st_q);
				dv_q <= et_q - st_q;
				q_q <= '0;
			end
			ST_DIV: begin
				q_q <= {q_q[15:0], ge};
				r_q <= {rem[23:0], 1'b0};
				if (div_cnt_q == 5'd0) u_q <= {q_q[15:0], ge};
			end
			ST_SHAPE: begin
				pos_q <= !sb_q[15];
				x_q <= sb_q[15] ? 17'h10000 - u_q : u_q;
				e_q <= 18'(19'd32768 + {babs, 2'b00});
				uz_q <= u_q;
				if (sb_q[15] ? (u_q == 17'h10000) : (u_q == '0)) p_q <= '0;
				else p_q <= 17'h10000;
			end
			ST_PLOG: begin
				if (mu_rsp.done) dl_q <= 21'(32'h100000 - mu_rsp.value);
			end
			ST_PMUL: neg_q <= 24'((39'(dl_q) * 39'(e_q)) >> 15);
			ST_PCHK: begin
				if (neg_q > 24'h100000) p_q <= '0;
			end
			ST_PEXP: begin
				if (mu_rsp.done)
					p_q <= (mu_rsp.value > 32'h10000) ? 17'h10000 : 17'(mu_rsp.value);
			end
			ST_PFIN: uz_q <= pos_q ? p_q : 17'h10000 - p_q;
			ST_LMUL, ST_GMUL: prod_q <= dif_a * $signed({1'b0, uz_q});
			ST_LSUM: level_q <= sv_q + 32'(prod_q >>> 16);
			ST_GLS: begin
				if (mu_rsp.done) ls_q <= mu_rsp.value;
			end
			ST_GLE: begin
				if (mu_rsp.done) le_q <= mu_rsp.value;
			end
			ST_GSUM: y_q <= ls_q + 32'(prod_q >>> 16);
			ST_GEXP: begin
				if (mu_rsp.done) level_q <= mu_rsp.value;
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_done_eval: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> it_q.action == ACT_EVAL)
		else $error("result strobe for a write transaction");
	a_we_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> it_q.action == ACT_WRITE)
		else $error("memory write during evaluate");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy after result strobe");
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q == 5'd0) |=> state_q == ST_SHAPE)
		else $error("divider did not finish");
`endif

endmodule

/* dv/tb_breakpoint_envelope_evaluator.sv */
// self-checking testbench of the breakpoint envelope evaluator with a fixed-point level predictor
module tb_breakpoint_envelope_evaluator import bpe_pkg::*;;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;
	logic    cfg_valid;
	logic    cfg_ready;
	logic    cfg_data;

	breakpoint_envelope_evaluator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// predictor state
	logic [23:0]        env_time [POINTS];
	logic signed [31:0] env_level [POINTS];
	logic signed [15:0] env_bend [POINTS];
	logic               geo_mode;
	logic [31:0]        log_lut [0:LOG_TABLE_ENTRIES];
	logic [31:0]        exp_lut [0:LOG_TABLE_ENTRIES];

	item_t   pending_items [$];
	result_t expected_levels [$];
	int      n_errors;
	int      n_evals;
	int      n_writes;
	int      n_checked;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bt;
		v = v_in;
		res = '0;
		bt = 64'h1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	task automatic fill_luts();
		logic [63:0] roots [1:16];
		logic [63:0] c;
		logic [63:0] m;
		logic [63:0] f;
		logic [31:0] r;
		c = 64'h2 << 30;
		for (int j = 1; j <= 16; j++) begin
			c = int_sqrt(c << 30);
			roots[j] = c;
		end
		for (int k = 0; k < LOG_TABLE_ENTRIES; k++) begin
			m = (64'h1 << 30) + ((64'(k) << 30) / LOG_TABLE_ENTRIES);
			r = 0;
			for (int b = 15; b >= 0; b--) begin
				m = (m * m) >> 30;
				if (m >= (64'h2 << 30)) begin
					m = m >> 1;
					r[b] = 1'b1;
				end
			end
			log_lut[k] = r;
			f = (64'(k) << 16) / LOG_TABLE_ENTRIES;
			m = 64'h1 << 30;
			for (int j = 1; j <= 16; j++)
				if (f[16 - j]) m = (m * roots[j]) >> 30;
			exp_lut[k] = 32'(m >> 14);
		end
		log_lut[LOG_TABLE_ENTRIES] = 32'd65536;
		exp_lut[LOG_TABLE_ENTRIES] = 32'd131072;
	endtask

	function automatic logic [31:0] log2_fix(input logic [31:0] x);
		int unsigned p;
		logic [63:0] m;
		logic [63:0] s;
		logic [63:0] r;
		int unsigned k;
		logic [31:0] lo;
		logic [31:0] hi;
		p = 31;
		while (p > 0 && x[p] == 1'b0) p--;
		m = (p <= 30) ? (64'(x) << (30 - p)) : (64'(x) >> 1);
		s = (m - (64'h1 << 30)) * LOG_TABLE_ENTRIES;
		k = 32'(s >> 30);
		if (k >= LOG_TABLE_ENTRIES) k = LOG_TABLE_ENTRIES - 1;
		r = s & ((64'h1 << 30) - 1);
		lo = log_lut[k];
		hi = log_lut[k + 1];
		return (32'(p) << 16) + lo + 32'((64'(hi - lo) * r) >> 30);
	endfunction

	function automatic logic [31:0] exp2_fix(input logic [31:0] y);
		logic [31:0] ip;
		logic [63:0] s;
		logic [63:0] m;
		logic [63:0] v;
		int unsigned k;
		logic [31:0] lo;
		logic [31:0] hi;
		ip = y >> 16;
		s = 64'(y[15:0]) * LOG_TABLE_ENTRIES;
		k = 32'(s >> 16);
		if (k >= LOG_TABLE_ENTRIES) k = LOG_TABLE_ENTRIES - 1;
		lo = exp_lut[k];
		hi = exp_lut[k + 1];
		m = 64'(lo) + ((64'(hi - lo) * (s & 64'hFFFF)) >> 16);
		if (ip >= 40) return 32'h7FFFFFFF;
		v = (ip >= 16) ? (m << (ip - 16)) : (m >> (16 - ip));
		return (v > 64'h7FFFFFFF) ? 32'h7FFFFFFF : 32'(v);
	endfunction

	function automatic logic [31:0] pow_frac(input logic [31:0] x, input logic [31:0] e);
		logic [63:0] d;
		logic [63:0] neg;
		logic [31:0] r;
		if (x == 0) return 0;
		if (x >= 65536) return 65536;
		d = 64'((32'd16 << 16) - log2_fix(x));
		neg = (d * 64'(e)) >> 15;
		if (neg > (64'd16 << 16)) return 0;
		r = exp2_fix(32'((64'd16 << 16) - neg));
		return (r > 65536) ? 32'd65536 : r;
	endfunction

	function automatic logic [31:0] bend_frac(input logic [31:0] u, input logic signed [15:0] b);
		if (b == 0) return u;
		if (b > 0) return pow_frac(u, 32'(32768 + 4 * int'(b)));
		return 65536 - pow_frac(65536 - u, 32'(32768 - 4 * int'(b)));
	endfunction

	function automatic longint floor_q16(input longint p);
		if (p >= 0) return p >>> 16;
		return -((-p + 65535) >>> 16);
	endfunction

	function automatic logic signed [31:0] level_at(input logic [23:0] t);
		logic [23:0]        st;
		logic [23:0]        et;
		logic [31:0]        u;
		logic [63:0]        q;
		longint             sv;
		longint             ev;
		longint             ls;
		longint             le;
		if (t <= env_time[0]) return env_level[0];
		if (t >= env_time[POINTS - 1]) return env_level[POINTS - 1];
		for (int i = 0; i + 1 < POINTS; i++) begin
			st = env_time[i];
			et = env_time[i + 1];
			sv = env_level[i];
			ev = env_level[i + 1];
			if (t > et) continue;
			if (et <= st) u = 65536;
			else if (t <= st) u = 0;
			else begin
				q = (64'(t - st) << 16) / 64'(et - st);
				u = (q > 65536) ? 32'd65536 : 32'(q);
			end
			u = bend_frac(u, env_bend[i]);
			if (geo_mode) begin
				if (sv < 66) sv = 66;
				if (ev < 66) ev = 66;
				ls = log2_fix(32'(sv));
				le = log2_fix(32'(ev));
				return exp2_fix(32'(ls + floor_q16((le - ls) * longint'(u))));
			end
			return 32'(sv + floor_q16((ev - sv) * longint'(u)));
		end
		return env_level[POINTS - 1];
	endfunction

	task automatic apply_item(input item_t it);
		logic [24:0] lowest;
		logic [23:0] t;
		result_t     r;
		if (it.action == ACT_WRITE) begin
			n_writes++;
			t = it.point_time;
			if (it.point_index == 0) t = 0;
			else begin
				lowest = 25'(env_time[it.point_index - 1]) + TIME_GAP;
				if (lowest > 25'(TIME_MAX)) lowest = 25'(TIME_MAX);
				if (25'(t) < lowest) t = lowest[23:0];
			end
			env_time[it.point_index] = t;
			env_level[it.point_index] = it.point_level;
			env_bend[it.point_index] = it.point_bend;
		end else begin
			n_evals++;
			r.level = level_at(it.eval_time);
			r.total_duration = env_time[POINTS - 1];
			expected_levels.push_back(r);
		end
	endtask

	function automatic item_t rand_item();
		item_t it;
		it.action = action_t'($urandom_range(0, 1));
		it.point_index = 3'($urandom);
		it.point_time = 24'($urandom);
		it.point_level = $urandom;
		it.point_bend = 16'($urandom);
		it.eval_time = 24'($urandom);
		return it;
	endfunction

	function automatic item_t write_item(input int idx, input logic [23:0] t,
			input logic [31:0] lvl, input logic [15:0] bnd);
		item_t it;
		it = rand_item();
		it.action = ACT_WRITE;
		it.point_index = 3'(idx);
		it.point_time = t;
		it.point_level = lvl;
		it.point_bend = bnd;
		return it;
	endfunction

	function automatic item_t eval_item(input logic [23:0] t);
		item_t it;
		it = rand_item();
		it.action = ACT_EVAL;
		it.eval_time = t;
		return it;
	endfunction

	// builds an ordered envelope of eight points, then evaluations across it
	task automatic queue_envelope(input int n_eval, input bit wide);
		logic [23:0] t;
		logic [31:0] lvl;
		logic [15:0] bnd;
		logic [23:0] span;
		t = 0;
		span = wide ? 24'h1FFFFF : 24'd3000;
		for (int i = 0; i < POINTS; i++) begin
			t = t + 24'($urandom_range(0, span));
			case ($urandom_range(0, 3))
				0: lvl = $urandom;
				1: lvl = 32'($urandom_range(0, 32'h00FFFFFF));
				2: lvl = 32'($urandom_range(0, 200));
				default: lvl = -32'($urandom_range(0, 32'h00FFFFFF));
			endcase
			case ($urandom_range(0, 4))
				0: bnd = 16'h0000;
				1: bnd = 16'h7FFF;
				2: bnd = 16'h8000;
				default: bnd = 16'($urandom);
			endcase
			pending_items.push_back(write_item(i, t, lvl, bnd));
		end
		for (int i = 0; i < n_eval; i++)
			pending_items.push_back(eval_item(24'($urandom_range(0, int'(t) + 100))));
	endtask

	// driver
	int  gap_left;
	bit  hold_for_drain;
	bit  cfg_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			gap_left <= 0;
		end else if (start && !busy) begin
			apply_item(item);
			if (pending_items.size() > 0 && $urandom_range(0, 5) == 0 && !cfg_phase
					&& !hold_for_drain) begin
				item <= pending_items.pop_front();
			end else begin
				start <= 1'b0;
				gap_left <= $urandom_range(0, 5);
			end
		end else if (!start) begin
			if (gap_left > 0) gap_left <= gap_left - 1;
			else if (pending_items.size() > 0 && !cfg_phase && !hold_for_drain) begin
				start <= 1'b1;
				item <= pending_items.pop_front();
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_levels.size() == 0) begin
				$display("%0t unexpected result level=%h duration=%h", $time, result.level,
					result.total_duration);
				n_errors++;
			end else begin
				want = expected_levels.pop_front();
				n_checked++;
				if (result.level !== want.level) begin
					$display("%0t level expected %h actual %h", $time, want.level,
						result.level);
					n_errors++;
				end
				if (result.total_duration !== want.total_duration) begin
					$display("%0t total_duration expected %h actual %h", $time,
						want.total_duration, result.total_duration);
					n_errors++;
				end
			end
		end
	end

	task automatic wait_idle();
		while (pending_items.size() > 0 || start || expected_levels.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		geo_mode = m;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		n_errors = 0;
		n_evals = 0;
		n_writes = 0;
		n_checked = 0;
		hold_for_drain = 0;
		cfg_phase = 0;
		geo_mode = 0;
		for (int i = 0; i < POINTS; i++) begin
			env_time[i] = 0;
			env_level[i] = 0;
			env_bend[i] = 0;
		end
		fill_luts();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset table, extremes, out-of-order and crowded times
		pending_items.push_back(eval_item(24'h000000));
		pending_items.push_back(eval_item(24'hFFFFFF));
		pending_items.push_back(write_item(0, 24'hFFFFFF, 32'h7FFFFFFF, 16'h7FFF));
		pending_items.push_back(write_item(1, 24'h000000, 32'h80000000, 16'h8000));
		pending_items.push_back(write_item(2, 24'd100, 32'h00010000, 16'h0000));
		pending_items.push_back(write_item(3, 24'd50, 32'h00000000, 16'h4000));
		pending_items.push_back(write_item(4, 24'd1000, 32'hFFFF0000, 16'hC000));
		pending_items.push_back(write_item(5, 24'hFFFFF0, 32'h00000042, 16'h0001));
		pending_items.push_back(write_item(6, 24'hFFFFFE, 32'h00000001, 16'hFFFF));
		pending_items.push_back(write_item(7, 24'd5, 32'h12345678, 16'h2000));
		pending_items.push_back(eval_item(24'd0));
		pending_items.push_back(eval_item(24'd5));
		pending_items.push_back(eval_item(24'd15));
		pending_items.push_back(eval_item(24'd25));
		pending_items.push_back(eval_item(24'd40));
		pending_items.push_back(eval_item(24'd500));
		pending_items.push_back(eval_item(24'hFFFFF8));
		pending_items.push_back(eval_item(24'hFFFFFF));
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			cfg_phase = 1;
			write_mode(phase[0]);
			cfg_phase = 0;
			for (int k = 0; k < 11; k++) begin
				if ($urandom_range(0, 4) == 0) begin
					for (int j = 0; j < 5; j++) pending_items.push_back(rand_item());
				end else begin
					queue_envelope($urandom_range(4, 10), $urandom_range(0, 1));
				end
			end
			if (phase == 2) begin
				hold_for_drain = 1;
				while (start || expected_levels.size() > 0) @(posedge clk);
				hold_for_drain = 0;
			end
			wait_idle();
		end
		$display("covered %0d breakpoint writes and %0d evaluations, %0d results checked",
			n_writes, n_evals, n_checked);
		$display("both interpolation modes exercised over three passes each");
		if (n_errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
